### design/u2c_pkg.sv
package u2c_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CodeWidth  = 21;
   localparam int unsigned BufDepth   = 4;

   localparam logic [ByteWidth-1:0] MarkerReset = 8'hFF;
   localparam logic [CodeWidth-1:0] SubstCode   = 21'h00FFFD;

   // lead length codes
   localparam logic [2:0] LenNone  = 3'd0;
   localparam logic [2:0] LenOne   = 3'd1;
   localparam logic [2:0] LenTwo   = 3'd2;
   localparam logic [2:0] LenThree = 3'd3;
   localparam logic [2:0] LenFour  = 3'd4;

   typedef struct packed {
      logic use_input;  // decode window built from held bytes plus the live byte
      logic hold;       // store live byte as part of an open sequence
      logic emit;       // load result register from the decoder
      logic load_run;   // store live byte and start replaying the buffer
      logic clear;      // buffer consumed, sequence closed
   } cmd_type;

   typedef struct packed {
      logic will_hold;
      logic step_last;
   } status_type;

   function automatic logic [2:0] lead_len(input logic [ByteWidth-1:0] c);
      logic [2:0] len;
      case (c) inside
         [8'hC0:8'hDF]: len = LenTwo;
         [8'hE0:8'hEF]: len = LenThree;
         [8'hF0:8'hF7]: len = LenFour;
         default:       len = LenNone;
      endcase
      return len;
   endfunction

endpackage

### design/u2c_if.sv
interface u2c_req_if;
   logic                            valid;
   logic                            ready;
   logic [u2c_pkg::ByteWidth-1:0]   in_byte;
   logic                            string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface u2c_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [u2c_pkg::CodeWidth-1:0]   code_point;
   logic                            newline_mark;
   logic                            malformed_sub;
   logic                            decoded_sub;
   logic                            run_last;

   modport source (output valid, output code_point, output newline_mark,
                   output malformed_sub, output decoded_sub, output run_last,
                   input ready);
   modport sink   (input valid, input code_point, input newline_mark,
                   input malformed_sub, input decoded_sub, input run_last,
                   output ready);
endinterface

### design/utf8_to_codepoint_decoder.sv
// Channel       Dir   Handshake      Payload
// req_channel   in    valid/ready    in_byte[7:0], string_end
// rsp_channel   out   valid/ready    code_point[20:0], newline_mark, malformed_sub,
//                                    decoded_sub, run_last
// csr_*         in    write enable   eol marker byte[7:0]
//
// One byte per cycle while req_ready is high: a byte that extends an open sequence
// is held, any other byte yields its result into the output register in the cycle
// it is taken. A sequence cut short by string end replays the buffered bytes, one
// result a cycle unless stalled; req_ready is low for the remaining results.
// The single output register gives one result per cycle while rsp_ready is high.
// Reset is synchronous; it clears the open sequence and sets the marker to 0xFF.
module utf8_to_codepoint_decoder (
   input  logic                           clock,
   input  logic                           reset,
   u2c_req_if.sink                        req_channel,
   u2c_rsp_if.source                      rsp_channel,
   input  logic                           csr_write_enable,
   input  logic [u2c_pkg::ByteWidth-1:0]  csr_write_data
);

   u2c_pkg::cmd_type    cmd;
   u2c_pkg::status_type status;

   u2c_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   u2c_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_byte         (req_channel.in_byte),
      .req_end          (req_channel.string_end),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .code_point       (rsp_channel.code_point),
      .newline_mark     (rsp_channel.newline_mark),
      .malformed_sub    (rsp_channel.malformed_sub),
      .decoded_sub      (rsp_channel.decoded_sub),
      .run_last         (rsp_channel.run_last)
   );

endmodule

### design/u2c_datapath.sv
module u2c_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [u2c_pkg::ByteWidth-1:0]    req_byte,
   input  logic                             req_end,
   input  logic                             csr_write_enable,
   input  logic [u2c_pkg::ByteWidth-1:0]    csr_write_data,
   input  u2c_pkg::cmd_type                 cmd,
   output u2c_pkg::status_type              status,
   output logic [u2c_pkg::CodeWidth-1:0]    code_point,
   output logic                             newline_mark,
   output logic                             malformed_sub,
   output logic                             decoded_sub,
   output logic                             run_last
);

   logic [u2c_pkg::ByteWidth-1:0] buf_ff [u2c_pkg::BufDepth];
   logic [1:0]                    hc_ff, hc_in;
   logic [2:0]                    seq_ff, seq_in;
   logic [1:0]                    ptr_ff, ptr_in;
   logic [2:0]                    n_ff, n_in;
   logic [u2c_pkg::ByteWidth-1:0] marker_ff, marker_in;

   logic [u2c_pkg::CodeWidth-1:0] cp_ff;
   logic                          nl_ff, mal_ff, dec_ff, last_ff;

   logic [u2c_pkg::ByteWidth-1:0] vbuf [u2c_pkg::BufDepth];
   logic [u2c_pkg::ByteWidth-1:0] win  [u2c_pkg::BufDepth];
   logic [1:0]                    ptr_eff;
   logic [2:0]                    n_eff, rem, len, len_in, consume;
   logic [u2c_pkg::CodeWidth-1:0] cp;
   logic                          nl, mal, dec;
   logic [u2c_pkg::ByteWidth-1:0] c;

   // held bytes with the live byte dropped in at the fill position
   always_comb begin
      for (int k = 0; k < u2c_pkg::BufDepth; k++) begin
         vbuf[k] = (cmd.use_input && hc_ff == 2'(k)) ? req_byte : buf_ff[k];
      end
   end

   assign ptr_eff = cmd.use_input ? 2'd0 : ptr_ff;
   assign n_eff   = cmd.use_input ? ({1'b0, hc_ff} + 3'd1) : n_ff;
   assign rem     = n_eff - {1'b0, ptr_eff};

   always_comb begin
      logic [2:0] idx;
      for (int j = 0; j < u2c_pkg::BufDepth; j++) begin
         idx    = {1'b0, ptr_eff} + 3'(j);
         win[j] = idx[2] ? '0 : vbuf[idx[1:0]];
      end
   end

   assign c   = win[0];
   assign len = u2c_pkg::lead_len(c);

   always_comb begin
      cp      = '0;
      nl      = 1'b0;
      mal     = 1'b0;
      dec     = 1'b0;
      consume = u2c_pkg::LenOne;
      if (!c[7]) begin
         cp = {13'd0, c};
      end else if (c == marker_ff) begin
         nl = 1'b1;
      end else if (len != u2c_pkg::LenNone && len <= rem) begin
         case (len)
            u2c_pkg::LenTwo:   cp = {10'd0, c[4:0], win[1][5:0]};
            u2c_pkg::LenThree: cp = {5'd0, c[3:0], win[1][5:0], win[2][5:0]};
            u2c_pkg::LenFour:  cp = {c[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
            default:           cp = '0;
         endcase
         consume = len;
         dec     = (cp == u2c_pkg::SubstCode);
      end else begin
         cp  = u2c_pkg::SubstCode;
         mal = 1'b1;
      end
   end

   assign len_in = u2c_pkg::lead_len(req_byte);

   always_comb begin
      if (seq_ff == 3'd0) begin
         status.will_hold = !req_end && req_byte[7] && (req_byte != marker_ff)
                            && (len_in != u2c_pkg::LenNone);
      end else begin
         status.will_hold = !req_end && (({1'b0, hc_ff} + 3'd1) < seq_ff);
      end
      status.step_last = (({1'b0, ptr_eff} + consume) >= n_eff);
   end

   always_comb begin
      hc_in     = hc_ff;
      seq_in    = seq_ff;
      ptr_in    = ptr_ff;
      n_in      = n_ff;
      marker_in = csr_write_enable ? csr_write_data : marker_ff;
      if (cmd.hold) begin
         hc_in = hc_ff + 2'd1;
         if (seq_ff == 3'd0) begin
            seq_in = len_in;
         end
      end
      if (cmd.emit) begin
         ptr_in = ptr_eff + consume[1:0];
      end
      if (cmd.load_run) begin
         n_in   = n_eff;
         hc_in  = 2'd0;
         seq_in = 3'd0;
      end
      if (cmd.clear) begin
         hc_in  = 2'd0;
         seq_in = 3'd0;
         ptr_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff     <= '0;
         seq_ff    <= '0;
         ptr_ff    <= '0;
         n_ff      <= '0;
         marker_ff <= u2c_pkg::MarkerReset;
      end else begin
         hc_ff     <= hc_in;
         seq_ff    <= seq_in;
         ptr_ff    <= ptr_in;
         n_ff      <= n_in;
         marker_ff <= marker_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hold || cmd.load_run) begin
         buf_ff[hc_ff] <= req_byte;
      end
      if (cmd.emit) begin
         cp_ff   <= cp;
         nl_ff   <= nl;
         mal_ff  <= mal;
         dec_ff  <= dec;
         last_ff <= status.step_last;
      end
   end

   assign code_point    = cp_ff;
   assign newline_mark  = nl_ff;
   assign malformed_sub = mal_ff;
   assign decoded_sub   = dec_ff;
   assign run_last      = last_ff;

`ifndef SYNTHESIS
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == 3'd0) |-> (hc_ff == 2'd0))
      else $error("held bytes present with no open sequence");

   a_open_fill: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != 3'd0) |-> (seq_ff >= 3'd2 && {1'b0, hc_ff} < seq_ff && hc_ff != 2'd0))
      else $error("open sequence fill out of range");

   a_replay_ptr: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !cmd.use_input) |-> (ptr_ff != 2'd0 && {1'b0, ptr_ff} < n_ff))
      else $error("replay pointer beyond buffered bytes");
`endif

endmodule

### design/u2c_controller.sv
module u2c_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  u2c_pkg::status_type  status,
   output u2c_pkg::cmd_type     cmd
);

   typedef enum logic {
      ST_ACCEPT,
      ST_REPLAY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_ACCEPT) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_ACCEPT: begin
            cmd.use_input = 1'b1;
            if (accept) begin
               if (status.will_hold) begin
                  cmd.hold = 1'b1;
               end else begin
                  cmd.emit     = 1'b1;
                  rsp_valid_in = 1'b1;
                  if (status.step_last) begin
                     cmd.clear = 1'b1;
                  end else begin
                     cmd.load_run = 1'b1;
                     state_in     = ST_REPLAY;
                  end
               end
            end
         end
         ST_REPLAY: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.step_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_ACCEPT;
               end
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_load_enters_replay: assert property (@(posedge clock) disable iff (reset)
      cmd.load_run |=> (state_ff == ST_REPLAY && rsp_valid_ff))
      else $error("replay not started after truncated sequence");

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.emit)
      else $error("result register overwritten while stalled");

   a_no_input_in_replay: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLAY) |-> !(cmd.hold || cmd.load_run || cmd.use_input))
      else $error("input taken during replay");
`endif

endmodule
